>>> sv/bde_pkg.sv
// bde_pkg: shared types and codes for the byte deque engine
// used by bde_ctrl, bde_dp and byte_deque_engine; no dependencies

package bde_pkg;

    // request modes (codes above MODE_QUERY act as query)
    localparam logic [2:0] MODE_PUSH_FRONT = 3'd0;
    localparam logic [2:0] MODE_PUSH_BACK  = 3'd1;
    localparam logic [2:0] MODE_POP_FRONT  = 3'd2;
    localparam logic [2:0] MODE_POP_BACK   = 3'd3;
    localparam logic [2:0] MODE_QUERY      = 3'd4;

    // result status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    // controller to datapath commands
    typedef struct packed {
        logic latch;    // capture the request fields
        logic exec;     // apply the request to pointers and memory
        logic capture;  // load the refreshed end byte from memory
    } t_dp_cmd;

    // datapath to controller status
    typedef struct packed {
        logic need_read;  // a pop left bytes, so the new end byte must be fetched
    } t_dp_sts;

endpackage

>>> sv/bde_ram.sv
// bde_ram: generic single-write, single-read memory with registered read data
// no dependencies

module bde_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [WIDTH-1:0]  i_wdata,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/bde_ctrl.sv
// bde_ctrl: sequencer for the byte deque engine
// depends on bde_pkg for the command and status structs

module bde_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    output logic             o_done,
    output bde_pkg::t_dp_cmd o_cmd,
    input  bde_pkg::t_dp_sts i_sts
);

    import bde_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_READ = 4'b0100,
        S_OUT  = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_state = i_sts.need_read ? S_READ : S_OUT;
            end
            S_READ: begin
                n_state = S_OUT;
            end
            S_OUT: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy          = (r_state != S_IDLE);
    assign o_done        = (r_state == S_OUT);
    assign o_cmd.latch   = (r_state == S_IDLE) && start;
    assign o_cmd.exec    = (r_state == S_EXEC);
    assign o_cmd.capture = (r_state == S_READ);

`ifndef ASSERT_OFF
    a_accept_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("accepted request did not raise busy");

    a_done_then_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !busy)
        else $error("controller did not return to idle after result");

    a_read_after_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |-> $past(o_cmd.exec) && $past(i_sts.need_read))
        else $error("memory capture without a preceding pop");

    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.latch, o_cmd.exec, o_cmd.capture, o_done}))
        else $error("overlapping controller commands");
`endif

endmodule

>>> sv/bde_dp.sv
// bde_dp: ring pointers, count, cached end bytes and result registers
// depends on bde_pkg and instantiates bde_ram for the byte store

module bde_dp #(
    parameter int DEPTH = 64,
    localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  bde_pkg::t_dp_cmd i_cmd,
    output bde_pkg::t_dp_sts o_sts,
    input  logic [2:0]       i_mode,
    input  logic [7:0]       i_push_value,
    output logic [7:0]       o_popped_value,
    output logic [7:0]       o_front_value,
    output logic [7:0]       o_back_value,
    output logic [CNT_W-1:0] o_entry_count,
    output logic             o_is_empty,
    output logic [1:0]       o_status
);

    import bde_pkg::*;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    // control state
    logic [IDX_W-1:0] r_front, n_front;
    logic [IDX_W-1:0] r_back,  n_back;
    logic [CNT_W-1:0] r_count, n_count;

    // payload
    logic [2:0]       r_mode, n_mode;
    logic [7:0]       r_value, n_value;
    logic [7:0]       r_front_byte, n_front_byte;
    logic [7:0]       r_back_byte, n_back_byte;
    logic [7:0]       r_popped, n_popped;
    logic [1:0]       r_status, n_status;

    logic [IDX_W-1:0] front_inc, front_dec, back_inc, back_dec;
    logic             is_full, is_empty_now;
    logic             ram_we;
    logic [IDX_W-1:0] ram_waddr, ram_raddr;
    logic [7:0]       ram_rdata;
    logic             need_read;

    assign front_inc    = (r_front == LAST_IDX) ? '0 : r_front + IDX_W'(1);
    assign front_dec    = (r_front == '0) ? LAST_IDX : r_front - IDX_W'(1);
    assign back_inc     = (r_back == LAST_IDX) ? '0 : r_back + IDX_W'(1);
    assign back_dec     = (r_back == '0) ? LAST_IDX : r_back - IDX_W'(1);
    assign is_full      = (r_count == FULL_CNT);
    assign is_empty_now = (r_count == '0);

    always_comb begin
        n_front      = r_front;
        n_back       = r_back;
        n_count      = r_count;
        n_mode       = r_mode;
        n_value      = r_value;
        n_front_byte = r_front_byte;
        n_back_byte  = r_back_byte;
        n_popped     = r_popped;
        n_status     = r_status;
        ram_we       = 1'b0;
        ram_waddr    = r_front;
        ram_raddr    = r_front;
        need_read    = 1'b0;

        if (i_cmd.latch) begin
            n_mode  = i_mode;
            n_value = i_push_value;
        end

        if (i_cmd.exec) begin
            n_popped = '0;
            n_status = ST_OK;
            case (r_mode)
                MODE_PUSH_FRONT: begin
                    if (is_full) begin
                        n_status = ST_FULL;
                    end else begin
                        n_front      = front_dec;
                        ram_we       = 1'b1;
                        ram_waddr    = front_dec;
                        n_count      = r_count + CNT_W'(1);
                        n_front_byte = r_value;
                        if (is_empty_now) begin
                            n_back      = front_dec;
                            n_back_byte = r_value;
                        end
                    end
                end
                MODE_PUSH_BACK: begin
                    if (is_full) begin
                        n_status = ST_FULL;
                    end else begin
                        n_back      = is_empty_now ? r_front : back_inc;
                        ram_we      = 1'b1;
                        ram_waddr   = is_empty_now ? r_front : back_inc;
                        n_count     = r_count + CNT_W'(1);
                        n_back_byte = r_value;
                        if (is_empty_now) begin
                            n_front_byte = r_value;
                        end
                    end
                end
                MODE_POP_FRONT: begin
                    if (is_empty_now) begin
                        n_status = ST_EMPTY;
                    end else begin
                        n_popped  = r_front_byte;
                        n_front   = front_inc;
                        n_count   = r_count - CNT_W'(1);
                        ram_raddr = front_inc;
                        need_read = (r_count != CNT_W'(1));
                    end
                end
                MODE_POP_BACK: begin
                    if (is_empty_now) begin
                        n_status = ST_EMPTY;
                    end else begin
                        n_popped  = r_back_byte;
                        n_back    = back_dec;
                        n_count   = r_count - CNT_W'(1);
                        ram_raddr = back_dec;
                        need_read = (r_count != CNT_W'(1));
                    end
                end
                default: begin
                    if (is_empty_now) begin
                        n_status = ST_EMPTY;
                    end
                end
            endcase
            // an emptied ring restarts at slot zero
            if (n_count == '0) begin
                n_front = '0;
            end
        end

        if (i_cmd.capture) begin
            if (r_mode == MODE_POP_FRONT) begin
                n_front_byte = ram_rdata;
            end else begin
                n_back_byte = ram_rdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front <= '0;
            r_back  <= '0;
            r_count <= '0;
        end else begin
            r_front <= n_front;
            r_back  <= n_back;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode       <= n_mode;
        r_value      <= n_value;
        r_front_byte <= n_front_byte;
        r_back_byte  <= n_back_byte;
        r_popped     <= n_popped;
        r_status     <= n_status;
    end

    bde_ram #(
        .WIDTH (8),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_value),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_sts.need_read = need_read;
    assign o_popped_value  = r_popped;
    assign o_front_value   = is_empty_now ? 8'd0 : r_front_byte;
    assign o_back_value    = is_empty_now ? 8'd0 : r_back_byte;
    assign o_entry_count   = r_count;
    assign o_is_empty      = is_empty_now;
    assign o_status        = r_status;

`ifndef ASSERT_OFF
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_CNT)
        else $error("entry count beyond ring depth");

    a_empty_front_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == '0) |-> (r_front == '0))
        else $error("empty ring with front pointer off slot zero");

    a_count_only_on_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_cmd.exec |=> $stable(r_count))
        else $error("count moved outside request execution");

    a_no_write_on_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        need_read |-> !ram_we)
        else $error("write and refresh read in the same cycle");
`endif

endmodule

>>> sv/byte_deque_engine.sv
// byte_deque_engine: top level of the double-ended byte queue
// depends on bde_pkg, bde_ctrl, bde_dp and bde_ram
//
// A request is taken at a rising edge where start is high and busy is low.
// i_mode selects push front, push back, pop front, pop back or query (codes
// above query act as query); i_push_value is the byte for a push.
// Every request gives exactly one result, shown for one cycle with o_done:
// the popped byte, the bytes now at front and back (zero when empty), the
// count held, an empty flag and a status (ok, pop or peek on empty, push on
// full dropped). The receiver cannot stall the result.
// After the accepting edge the request runs in an execute state, then, for a
// pop that leaves bytes behind, a read state, since the new end byte comes
// from the single read port of the byte memory, whose read is registered;
// the result follows in an output state. One request at a time: a new one
// is accepted only once the result of the last has gone and busy is low.
// Reset (synchronous, active low) empties the queue at once; the byte
// memory is not cleared, since only held bytes are ever read.

module byte_deque_engine #(
    parameter int DEPTH = 64,
    localparam int CNT_W = $clog2(DEPTH + 1)
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [2:0]       i_mode,
    input  logic [7:0]       i_push_value,
    output logic             o_done,
    output logic [7:0]       o_popped_value,
    output logic [7:0]       o_front_value,
    output logic [7:0]       o_back_value,
    output logic [CNT_W-1:0] o_entry_count,
    output logic             o_is_empty,
    output logic [1:0]       o_status
);

    import bde_pkg::*;

    t_dp_cmd dp_cmd;
    t_dp_sts dp_sts;

    bde_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .o_done  (o_done),
        .o_cmd   (dp_cmd),
        .i_sts   (dp_sts)
    );

    bde_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (dp_cmd),
        .o_sts          (dp_sts),
        .i_mode         (i_mode),
        .i_push_value   (i_push_value),
        .o_popped_value (o_popped_value),
        .o_front_value  (o_front_value),
        .o_back_value   (o_back_value),
        .o_entry_count  (o_entry_count),
        .o_is_empty     (o_is_empty),
        .o_status       (o_status)
    );

endmodule

>>> verif/byte_deque_engine_test.sv
// byte_deque_engine_test: self-checking testbench for the double-ended byte queue
// depends on bde_pkg and byte_deque_engine; a scoreboard class predicts every result
// while plain tasks send requests under varying gap rates and push/pop mixes

module byte_deque_engine_test;
    timeunit 1ns;
    timeprecision 1ps;

    import bde_pkg::*;

    localparam int DEPTH = 64;
    localparam int CNT_W = 7;
    localparam int CYCLE_LIMIT = 100000;

    typedef struct packed {
        logic [7:0]       popped;
        logic [7:0]       front;
        logic [7:0]       back;
        logic [CNT_W-1:0] count;
        logic             empty;
        logic [1:0]       status;
    } t_deque_result;

    class t_deque_scoreboard;
        logic [7:0]       slots [DEPTH];
        logic [5:0]       head;
        logic [CNT_W-1:0] held;
        t_deque_result    pending_results [$];
        int               errors;

        function new();
            head   = '0;
            held   = '0;
            errors = 0;
        endfunction

        task report_mismatch(input string what);
            $display("mismatch: %s", what);
            errors++;
        endtask

        function t_deque_result apply_request(input logic [2:0] mode, input logic [7:0] value);
            t_deque_result r;
            logic [2:0]    m;
            r = '0;
            m = (mode > MODE_QUERY) ? MODE_QUERY : mode;
            case (m)
                MODE_PUSH_FRONT: begin
                    if (held == DEPTH) begin
                        r.status = ST_FULL;
                    end else begin
                        head = head - 6'd1;
                        slots[head] = value;
                        held = held + 1'b1;
                    end
                end
                MODE_PUSH_BACK: begin
                    if (held == DEPTH) begin
                        r.status = ST_FULL;
                    end else begin
                        held = held + 1'b1;
                        slots[6'(head + held - 1)] = value;
                    end
                end
                MODE_POP_FRONT: begin
                    if (held == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        r.popped = slots[head];
                        head = head + 6'd1;
                        held = held - 1'b1;
                    end
                end
                MODE_POP_BACK: begin
                    if (held == 0) begin
                        r.status = ST_EMPTY;
                    end else begin
                        r.popped = slots[6'(head + held - 1)];
                        held = held - 1'b1;
                    end
                end
                default: begin
                    if (held == 0) r.status = ST_EMPTY;
                end
            endcase
            if (held == 0) begin
                head = '0;
            end else begin
                r.front = slots[head];
                r.back  = slots[6'(head + held - 1)];
            end
            r.count = held;
            r.empty = (held == 0);
            return r;
        endfunction

        task note_request(input logic [2:0] mode, input logic [7:0] value);
            pending_results.push_back(apply_request(mode, value));
        endtask

        task check_result(input t_deque_result got);
            t_deque_result want;
            if (pending_results.size() == 0) begin
                report_mismatch("result with no request outstanding");
            end else begin
                want = pending_results.pop_front();
                if (got.popped !== want.popped)
                    report_mismatch($sformatf("popped got %0h want %0h", got.popped, want.popped));
                if (got.front !== want.front)
                    report_mismatch($sformatf("front got %0h want %0h", got.front, want.front));
                if (got.back !== want.back)
                    report_mismatch($sformatf("back got %0h want %0h", got.back, want.back));
                if (got.count !== want.count)
                    report_mismatch($sformatf("count got %0d want %0d", got.count, want.count));
                if (got.empty !== want.empty)
                    report_mismatch($sformatf("empty got %0b want %0b", got.empty, want.empty));
                if (got.status !== want.status)
                    report_mismatch($sformatf("status got %0d want %0d", got.status, want.status));
            end
        endtask

        function int pending();
            return pending_results.size();
        endfunction
    endclass

    logic             i_clk;
    logic             i_rst_n;
    logic             start;
    logic             busy;
    logic [2:0]       i_mode;
    logic [7:0]       i_push_value;
    logic             o_done;
    logic [7:0]       o_popped_value;
    logic [7:0]       o_front_value;
    logic [7:0]       o_back_value;
    logic [CNT_W-1:0] o_entry_count;
    logic             o_is_empty;
    logic [1:0]       o_status;

    t_deque_scoreboard sb = new();
    int                cycles = 0;

    byte_deque_engine #(.DEPTH(DEPTH)) dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_mode         (i_mode),
        .i_push_value   (i_push_value),
        .o_done         (o_done),
        .o_popped_value (o_popped_value),
        .o_front_value  (o_front_value),
        .o_back_value   (o_back_value),
        .o_entry_count  (o_entry_count),
        .o_is_empty     (o_is_empty),
        .o_status       (o_status)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // results are taken with pre-edge values, one per strobe
    always @(posedge i_clk) begin
        if (i_rst_n && o_done)
            sb.check_result({o_popped_value, o_front_value, o_back_value,
                             o_entry_count, o_is_empty, o_status});
    end

    // hold the request until an edge with busy low takes it, then maybe pause
    task automatic send_request(input logic [2:0] mode, input logic [7:0] value,
                                input int idle_pct);
        bit free;
        int gap;
        start        <= 1'b1;
        i_mode       <= mode;
        i_push_value <= value;
        do begin
            @(negedge i_clk);
            free = !busy;
            @(posedge i_clk);
        end while (!free);
        sb.note_request(mode, value);
        if ($urandom_range(99) < idle_pct) begin
            start        <= 1'b0;
            i_mode       <= 3'($urandom);
            i_push_value <= 8'($urandom);
            gap = $urandom_range(1, 6);
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // push share swings between fill, mixed and drain so the ring reaches full and empty
    task automatic send_random(input int idx, input int idle_pct);
        int         push_pct;
        logic [2:0] mode;
        case ((idx / 100) % 4)
            0: push_pct = 88;
            1: push_pct = 50;
            2: push_pct = 12;
            default: push_pct = 50;
        endcase
        if ($urandom_range(99) < 5)
            mode = 3'($urandom_range(MODE_QUERY, 7));
        else if ($urandom_range(99) < push_pct)
            mode = $urandom_range(1) ? MODE_PUSH_BACK : MODE_PUSH_FRONT;
        else
            mode = $urandom_range(1) ? MODE_POP_BACK : MODE_POP_FRONT;
        send_request(mode, 8'($urandom), idle_pct);
    endtask

    initial begin
        int k;
        i_rst_n      <= 1'b0;
        start        <= 1'b0;
        i_mode       <= MODE_QUERY;
        i_push_value <= 8'h00;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // empty queue: peek and pops report empty, unused modes act as query
        send_request(MODE_QUERY, 8'h00, 11);
        send_request(MODE_POP_FRONT, 8'hFF, 11);
        send_request(MODE_POP_BACK, 8'h00, 11);
        send_request(3'd5, 8'hFF, 11);
        send_request(3'd6, 8'h00, 11);
        send_request(3'd7, 8'hFF, 11);
        // pushes at both ends, front one wrapping below index zero
        send_request(MODE_PUSH_BACK, 8'h00, 11);
        send_request(MODE_PUSH_BACK, 8'hFF, 11);
        send_request(MODE_PUSH_FRONT, 8'h55, 11);
        send_request(MODE_PUSH_FRONT, 8'hAA, 11);
        send_request(MODE_QUERY, 8'h12, 11);
        send_request(3'd7, 8'h34, 11);
        send_request(MODE_POP_BACK, 8'h00, 11);
        send_request(MODE_POP_FRONT, 8'h00, 11);
        send_request(MODE_POP_FRONT, 8'h00, 11);
        send_request(MODE_POP_BACK, 8'h00, 11);
        send_request(MODE_POP_BACK, 8'h00, 11);
        send_request(MODE_PUSH_FRONT, 8'hFF, 11);
        send_request(MODE_POP_BACK, 8'h00, 11);
        send_request(MODE_PUSH_BACK, 8'h80, 11);
        send_request(MODE_PUSH_FRONT, 8'h01, 11);
        send_request(MODE_POP_FRONT, 8'h00, 11);

        for (k = 0; k < 283; k++) send_random(k, 11);
        for (k = 283; k < 566; k++) send_random(k, 46);
        for (k = 566; k < 849; k++) send_random(k, 0);
        send_request(MODE_QUERY, 8'($urandom), 0);
        start <= 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (sb.pending() != 0)
            sb.report_mismatch($sformatf("%0d results never arrived", sb.pending()));
        if (sb.errors == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
